### rtl/kfli_pkg.sv
// ----------------------------------------------------------------------------
// kfli_pkg
// Shared types and constants for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kfli_pkg;

    localparam int KEYS       = 16;
    localparam int FRAC_BITS  = 16;
    localparam int KEY_IDX_W  = $clog2(KEYS);
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = 5;
    localparam int SEG_W      = 4;
    localparam int STAT_W     = 2;
    localparam int COMP_N     = 3;
    localparam int COMP_W     = 2;
    localparam int FACTOR_W   = 31;
    localparam int DIFF_W     = TIME_W + 1;
    localparam int DVD_W      = TIME_W + FRAC_BITS;
    localparam int PROD_W     = FACTOR_W + DIFF_W;
    localparam int QSTEP_W    = $clog2(FACTOR_W);

    localparam logic [FACTOR_W-1:0] FACTOR_MAX = {FACTOR_W{1'b1}};
    localparam logic [COMP_W-1:0]   COMP_LAST  = COMP_W'(COMP_N - 1);

    typedef enum logic [0:0] {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_PAST    = 2'd1,
        ST_ZERO    = 2'd2,
        ST_WRITTEN = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode                  opcode;
        logic [3:0]               key_index;
        logic [TIME_W-1:0]        time_value;
        logic signed [VAL_W-1:0]  value_x;
        logic signed [VAL_W-1:0]  value_y;
        logic signed [VAL_W-1:0]  value_z;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]  out_x;
        logic signed [VAL_W-1:0]  out_y;
        logic signed [VAL_W-1:0]  out_z;
        logic [SEG_W-1:0]         segment;
        t_status                  status;
    } t_out_item;

    typedef logic [COMP_N-1:0][VAL_W-1:0] t_vec3;

    typedef struct packed {
        logic [TIME_W-1:0] key_time;
        t_vec3             val;
    } t_key;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_READ  = 10'b00_0000_0010,
        S_CMP   = 10'b00_0000_0100,
        S_PREP  = 10'b00_0000_1000,
        S_DIVST = 10'b00_0001_0000,
        S_DIVW  = 10'b00_0010_0000,
        S_DELTA = 10'b00_0100_0000,
        S_MUL   = 10'b00_1000_0000,
        S_ACC   = 10'b01_0000_0000,
        S_FIN   = 10'b10_0000_0000
    } t_state;

endpackage

### rtl/kfli_in_if.sv
// ----------------------------------------------------------------------------
// kfli_in_if
// Valid/ready channel carrying one input item.
// ----------------------------------------------------------------------------
interface kfli_in_if import kfli_pkg::*; ();

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### rtl/kfli_out_if.sv
// ----------------------------------------------------------------------------
// kfli_out_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface kfli_out_if import kfli_pkg::*; ();

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

### rtl/kfli_div.sv
// ----------------------------------------------------------------------------
// kfli_div
// Restoring divider for the blend factor, one quotient bit per cycle,
// saturating to FACTOR_MAX.
// ----------------------------------------------------------------------------
module kfli_div import kfli_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DVD_W-1:0]    i_dividend,
    input  logic [TIME_W-1:0]   i_divisor,
    output logic                o_done,
    output logic [FACTOR_W-1:0] o_quot
);

    localparam int REM_W = TIME_W + 1;
    localparam logic [QSTEP_W-1:0] STEP_LAST = QSTEP_W'(FACTOR_W - 1);

    logic                r_busy;
    logic                r_chk;
    logic                r_done;
    logic                r_sat;
    logic [QSTEP_W-1:0]  r_cnt;
    logic [REM_W-1:0]    r_rem;
    logic [FACTOR_W-1:0] r_low;
    logic [FACTOR_W-1:0] r_q;
    logic [TIME_W-1:0]   r_dvs;

    logic [REM_W-1:0]    w_dvs;
    logic [REM_W-1:0]    w_trial;
    logic                w_ge;
    logic                w_ovf;

    assign w_dvs   = {1'b0, r_dvs};
    assign w_trial = {r_rem[TIME_W-1:0], r_low[FACTOR_W-1]};
    assign w_ge    = (w_trial >= w_dvs);
    // quotient would need more than FACTOR_W bits
    assign w_ovf   = (r_rem >= w_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chk  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_chk  <= 1'b1;
            end else if (r_busy && r_chk) begin
                if (w_ovf) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_chk <= 1'b0;
                end
            end else if (r_busy && (r_cnt == STEP_LAST)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= REM_W'(i_dividend[DVD_W-1:FACTOR_W]);
            r_low <= i_dividend[FACTOR_W-1:0];
            r_dvs <= i_divisor;
            r_sat <= 1'b0;
            r_cnt <= '0;
            r_q   <= '0;
        end else if (r_busy && r_chk) begin
            r_sat <= w_ovf;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - w_dvs) : w_trial;
            r_low <= {r_low[FACTOR_W-2:0], 1'b0};
            r_q   <= {r_q[FACTOR_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? FACTOR_MAX : r_q;

endmodule

### rtl/kfli_mul.sv
// ----------------------------------------------------------------------------
// kfli_mul
// Registered multiplier shared by the three components: factor times
// delta magnitude.
// ----------------------------------------------------------------------------
module kfli_mul import kfli_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [FACTOR_W-1:0] i_a,
    input  logic [DIFF_W-1:0]   i_b,
    output logic [PROD_W-1:0]   o_p
);

    logic [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

### rtl/keyframe_linear_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator
// Key store, scan sequencer and lerp datapath around a shared divider and
// multiplier.
// ----------------------------------------------------------------------------
// Write item: goes straight to S_FIN; its result is registered once the output
// register is free. Query: the key scan (on the single store read port) and the
// divide take most of its time. One item in flight; the next is taken once the
// result sits in the output register. Reset: key_count back to 1, control
// cleared, store kept.
// ----------------------------------------------------------------------------
module keyframe_linear_interpolator import kfli_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    kfli_in_if.sink          i_in,
    kfli_out_if.source       o_out
);

    t_state                r_state;
    logic [CNT_W-1:0]      r_key_count;
    logic [KEY_IDX_W-1:0]  r_idx;
    logic [KEY_IDX_W-1:0]  r_last;
    logic [TIME_W-1:0]     r_t;
    t_key                  r_mem [KEYS];
    t_key                  r_rd;
    t_key                  r_prev;
    t_key                  r_end;
    logic [SEG_W-1:0]      r_seg;
    t_status               r_status;
    t_vec3                 r_res;
    logic signed [DIFF_W-1:0] r_num;
    logic signed [DIFF_W-1:0] r_den;
    logic                  r_fneg;
    logic [FACTOR_W-1:0]   r_fmag;
    logic [COMP_W-1:0]     r_comp;
    logic [DIFF_W-1:0]     r_dmag;
    logic                  r_neg;
    logic                  r_ovalid;
    t_out_item             r_out;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [KEY_IDX_W-1:0]  w_last;
    logic [TIME_W-1:0]     w_num_mag;
    logic [TIME_W-1:0]     w_den_mag;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [FACTOR_W-1:0]   w_quot;
    logic [VAL_W-1:0]      w_s;
    logic [VAL_W-1:0]      w_e;
    logic signed [DIFF_W-1:0] w_se;
    logic signed [DIFF_W-1:0] w_ee;
    logic                  w_dneg;
    logic [PROD_W-1:0]     w_prod;
    logic [VAL_W-1:0]      w_psel;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        if (r_key_count == '0) begin
            w_last = '0;
        end else if (r_key_count > CNT_W'(KEYS)) begin
            w_last = KEY_IDX_W'(KEYS - 1);
        end else begin
            w_last = KEY_IDX_W'(r_key_count - 1'b1);
        end
    end

    assign w_num_mag = r_num[DIFF_W-1] ? TIME_W'(-r_num) : TIME_W'(r_num);
    assign w_den_mag = r_den[DIFF_W-1] ? TIME_W'(-r_den) : TIME_W'(r_den);
    assign w_div_start = (r_state == S_DIVST) && (r_den != '0);

    assign w_s    = r_prev.val[r_comp];
    assign w_e    = r_end.val[r_comp];
    assign w_se   = {w_s[VAL_W-1], w_s};
    assign w_ee   = {w_e[VAL_W-1], w_e};
    assign w_dneg = (w_ee < w_se);
    assign w_psel = w_prod[FRAC_BITS+VAL_W-1:FRAC_BITS];

    kfli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({w_num_mag, {FRAC_BITS{1'b0}}}),
        .i_divisor  (w_den_mag),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    kfli_mul u_mul (
        .i_clk (i_clk),
        .i_en  (r_state == S_MUL),
        .i_a   (r_fmag),
        .i_b   (r_dmag),
        .o_p   (w_prod)
    );

    // key store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in.data.opcode == OP_WRITE)) begin
            r_mem[KEY_IDX_W'(i_in.data.key_index)] <= {i_in.data.time_value,
                i_in.data.value_z, i_in.data.value_y, i_in.data.value_x};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_key_count <= i_cfg_wdata;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= (i_in.data.opcode == OP_WRITE) ? S_FIN : S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    priority if (r_idx == '0) begin
                        r_state <= (r_last == '0) ? S_FIN : S_READ;
                    end else if (r_t < r_rd.key_time) begin
                        r_state <= S_PREP;
                    end else if (r_idx == r_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_PREP: begin
                    r_state <= S_DIVST;
                end
                S_DIVST: begin
                    r_state <= (r_den == '0) ? S_FIN : S_DIVW;
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_state <= (r_comp == COMP_LAST) ? S_FIN : S_DELTA;
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_idx  <= '0;
                r_last <= w_last;
                r_t    <= i_in.data.time_value;
                r_res  <= '0;
                r_seg  <= i_in.data.key_index;
                r_status <= ST_WRITTEN;
            end
            S_CMP: begin
                priority if (r_idx == '0) begin
                    r_prev   <= r_rd;
                    r_res    <= r_rd.val;
                    r_seg    <= '0;
                    r_status <= ST_OK;
                    r_idx    <= KEY_IDX_W'(1);
                end else if (r_t < r_rd.key_time) begin
                    r_end <= r_rd;
                    r_seg <= SEG_W'(r_idx - 1'b1);
                end else if (r_idx == r_last) begin
                    r_res    <= r_rd.val;
                    r_seg    <= SEG_W'(r_idx);
                    r_status <= ST_PAST;
                end else begin
                    r_prev <= r_rd;
                    r_idx  <= r_idx + 1'b1;
                end
            end
            S_PREP: begin
                r_num <= $signed({1'b0, r_t}) - $signed({1'b0, r_prev.key_time});
                r_den <= $signed({1'b0, r_end.key_time})
                       - $signed({1'b0, r_prev.key_time});
            end
            S_DIVST: begin
                r_fneg   <= r_num[DIFF_W-1] ^ r_den[DIFF_W-1];
                r_res    <= r_prev.val;
                r_status <= (r_den == '0) ? ST_ZERO : ST_OK;
                r_comp   <= '0;
            end
            S_DIVW: begin
                r_fmag <= w_quot;
            end
            S_DELTA: begin
                r_dmag <= w_dneg ? DIFF_W'(w_se - w_ee) : DIFF_W'(w_ee - w_se);
                r_neg  <= r_fneg ^ w_dneg;
            end
            S_ACC: begin
                r_res[r_comp] <= r_neg ? (w_s - w_psel) : (w_s + w_psel);
                r_comp <= r_comp + 1'b1;
            end
            S_READ, S_MUL, S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_FIN) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && w_out_free) begin
            r_out.out_x   <= r_res[0];
            r_out.out_y   <= r_res[1];
            r_out.out_z   <= r_res[2];
            r_out.segment <= r_seg;
            r_out.status  <= r_status;
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_idx <= r_last))
        else $error("key scan ran past the last key in use");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIVW))
        else $error("divider finished outside its wait state");

    a_write_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in.data.opcode == OP_WRITE))
        |=> ((r_state == S_FIN) && (r_status == ST_WRITTEN)))
        else $error("write item did not go straight to its result");

    a_lerp_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ACC) && (r_comp == COMP_LAST)) |=> (r_state == S_FIN))
        else $error("component loop did not end after the last component");

endmodule
